### rtl/lzfb_pkg.sv
// lzfb_pkg: shared constants and types for the lzss flag-byte decoder
// no dependencies; compiled first

package lzfb_pkg;

    localparam int BYTE_W          = 8;
    localparam int TOTAL_W         = 24;
    localparam int COUNT_WIDTH_DEF = 24;

    // history window
    localparam int WINDOW_SIZE = 4096;
    localparam int HIST_AW     = $clog2(WINDOW_SIZE);
    localparam logic [HIST_AW:0] WIN_SPAN = (HIST_AW + 1)'(WINDOW_SIZE);

    // reference token fields
    localparam int NIB_W = 4;
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);

    // apb register file
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    typedef logic [PADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_MAX_LEN = t_reg_idx'(0);
    localparam logic [TOTAL_W-1:0] MAX_LEN_RST = {TOTAL_W{1'b1}};

    // history memory port
    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } t_mem_req;

endpackage

### rtl/lzfb_if.sv
// lzfb_if: valid/ready stream interfaces for compressed input and decoded output
// depends on lzfb_pkg

interface lzfb_in_if;
    import lzfb_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface lzfb_out_if;
    import lzfb_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               run_last;
    logic [TOTAL_W-1:0] produced_total;
    logic               limit_reached;

    modport source (output valid, output out_byte, output run_last,
                    output produced_total, output limit_reached, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input produced_total, input limit_reached, output ready);
endinterface

### rtl/lzfb_hist_ram.sv
// lzfb_hist_ram: 4096 x 8 history window, one write and one registered read port
// depends on lzfb_pkg

module lzfb_hist_ram (
    input  logic                    i_clk,
    input  lzfb_pkg::t_mem_req      i_req,
    output logic [lzfb_pkg::BYTE_W-1:0] o_rdata
);
    import lzfb_pkg::*;

    logic [BYTE_W-1:0] r_mem [WINDOW_SIZE];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lzfb_apb_cfg.sv
// lzfb_apb_cfg: apb register file holding the output length limit
// depends on lzfb_pkg

module lzfb_apb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [lzfb_pkg::APB_DW-1:0]   pwdata,
    output logic [lzfb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [lzfb_pkg::TOTAL_W-1:0]  o_max_len
);
    import lzfb_pkg::*;

    logic [TOTAL_W-1:0] r_max_len;
    t_reg_idx           w_idx;
    logic               w_wr;

    assign w_idx = paddr[PADDR_W-1:2];
    assign w_wr  = psel && penable && pwrite && (w_idx == REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (w_wr) begin
            r_max_len <= pwdata[TOTAL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_MAX_LEN) begin
            prdata = {{(APB_DW - TOTAL_W){1'b0}}, r_max_len};
        end
    end

    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

### rtl/lzss_flag_byte_decoder.sv
// lzss_flag_byte_decoder: lzss decoder over a 4096-byte history ram, apb limit register
// sequencing: each accepted byte is captured, then decoded; a back reference of length L
//   (3 to 18) copies its bytes one at a time, each copied byte is one ram read then write
// throughput: one input transfer per finished item; the output register frees the input side
// reset: synchronous active-low i_rst_n clears control state; the history ram is not cleared,
//   no clearing pass, since only bytes already written in the current stream are ever used
module lzss_flag_byte_decoder #(
    parameter int COUNT_WIDTH = lzfb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lzfb_in_if.sink                       i_in,
    lzfb_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [lzfb_pkg::APB_DW-1:0]   pwdata,
    output logic [lzfb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lzfb_pkg::*;

    localparam int EXT_W = COUNT_WIDTH + TOTAL_W;
    localparam logic [2:0] LAST_BIT = 3'd7;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // waiting for an input transfer
        ST_DEC  = 4'b0010,   // decode the captured byte
        ST_RD   = 4'b0100,   // issue history read for one copied byte
        ST_WR   = 4'b1000    // emit copied byte and write it back
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,     // next byte is a flag byte
        PH_TOKEN = 2'd1,     // next byte is a literal or distance low
        PH_DIST  = 2'd2      // next byte is the second reference byte
    } t_phase;

    // configuration
    logic [TOTAL_W-1:0] w_max_len;

    // stream state
    t_state                  r_state, n_state;
    t_phase                  r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]       r_flags, n_flags;
    logic [2:0]              r_idx, n_idx;
    logic [BYTE_W-1:0]       r_dist_low, n_dist_low;
    logic                    r_stopped, n_stopped;

    // captured item and copy bookkeeping
    logic [BYTE_W-1:0]       r_byte, n_byte;
    logic                    r_last, n_last;
    logic [HIST_AW-1:0]      r_dist, n_dist;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_zero, n_zero;

    // output register
    logic                    r_ov;
    logic [BYTE_W-1:0]       r_ob;
    logic                    r_rl;
    logic [TOTAL_W-1:0]      r_pt;
    logic                    r_lr;

    // datapath
    logic [COUNT_WIDTH-1:0]  w_cnt1;
    logic [EXT_W-1:0]        w_cnt_ext, w_cnt1_ext, w_max_ext, w_dist_ext;
    logic [HIST_AW:0]        w_dist_val;
    logic                    w_at_limit, w_next_limit;
    logic                    w_bit, w_slot;
    logic                    w_load, w_adv, w_fin;
    logic [BYTE_W-1:0]       w_ld_byte;
    logic                    w_ld_last;
    logic [BYTE_W-1:0]       w_rdata;
    t_mem_req                w_mem;

    lzfb_apb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    lzfb_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // count compares run at the summed width of the count and the 24-bit limit
    assign w_cnt1       = r_count + 1'b1;
    assign w_cnt_ext    = {{TOTAL_W{1'b0}}, r_count};
    assign w_cnt1_ext   = {{TOTAL_W{1'b0}}, w_cnt1};
    assign w_max_ext    = {{COUNT_WIDTH{1'b0}}, w_max_len};
    assign w_at_limit   = (w_cnt_ext >= w_max_ext);     // next emit attempt fails
    assign w_next_limit = (w_cnt1_ext >= w_max_ext);    // limit hit by this byte

    // distance field of zero stands for the full window
    assign w_dist_val = (r_dist == '0) ? WIN_SPAN : {1'b0, r_dist};
    assign w_dist_ext = {{(EXT_W - HIST_AW - 1){1'b0}}, w_dist_val};

    // current token bit, msb first
    assign w_bit  = r_flags[LAST_BIT - r_idx];

    // output register can take a new result this cycle
    assign w_slot = !r_ov || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_count    = r_count;
        n_flags    = r_flags;
        n_idx      = r_idx;
        n_dist_low = r_dist_low;
        n_stopped  = r_stopped;
        n_byte     = r_byte;
        n_last     = r_last;
        n_dist     = r_dist;
        n_len      = r_len;
        n_zero     = r_zero;
        w_load     = 1'b0;
        w_adv      = 1'b0;
        w_fin      = 1'b0;
        w_ld_byte  = r_byte;
        w_ld_last  = 1'b1;
        w_mem      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_byte  = i_in.in_byte;
                    n_last  = i_in.last_in;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                if (r_stopped) begin
                    // stream halted by the limit: bytes are swallowed until last
                    w_fin = 1'b1;
                end else begin
                    case (r_phase)
                        PH_FLAG: begin
                            n_flags = r_byte;
                            n_idx   = '0;
                            n_phase = PH_TOKEN;
                            w_fin   = 1'b1;
                        end
                        PH_TOKEN: begin
                            if (w_bit) begin
                                n_dist_low = r_byte;
                                n_phase    = PH_DIST;
                                w_fin      = 1'b1;
                            end else if (w_at_limit) begin
                                n_stopped = 1'b1;
                                w_adv     = 1'b1;
                                w_fin     = 1'b1;
                            end else if (w_slot) begin
                                // literal: single result, always run_last
                                w_load    = 1'b1;
                                w_ld_byte = r_byte;
                                w_adv     = 1'b1;
                                w_fin     = 1'b1;
                            end
                        end
                        PH_DIST: begin
                            n_dist  = {r_byte[BYTE_W-1:NIB_W], r_dist_low};
                            n_len   = {1'b0, r_byte[NIB_W-1:0]} + MIN_MATCH;
                            n_state = ST_RD;
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                if (w_at_limit) begin
                    // rest of the copy is dropped
                    n_stopped = 1'b1;
                    w_adv     = 1'b1;
                    w_fin     = 1'b1;
                end else begin
                    w_mem.re    = 1'b1;
                    w_mem.raddr = r_count[HIST_AW-1:0] - r_dist;
                    // reaching before the start of the stream reads zero
                    n_zero      = (w_cnt_ext < w_dist_ext);
                    n_state     = ST_WR;
                end
            end
            ST_WR: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_byte = r_zero ? '0 : w_rdata;
                    // last of the copy, or the next attempt is known to fail
                    w_ld_last = (r_len == LEN_W'(1)) || w_next_limit;
                    n_len     = r_len - 1'b1;
                    if (r_len == LEN_W'(1)) begin
                        w_adv = 1'b1;
                        w_fin = 1'b1;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // every produced byte lands in the history at the running count
        if (w_load) begin
            w_mem.we    = 1'b1;
            w_mem.waddr = r_count[HIST_AW-1:0];
            w_mem.wdata = w_ld_byte;
            n_count     = w_cnt1;
        end

        // step to the next flag bit
        if (w_adv) begin
            if (r_idx == LAST_BIT) begin
                n_phase = PH_FLAG;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_phase = PH_TOKEN;
            end
        end

        // item done; a marked last byte restarts the stream, partial token dropped
        if (w_fin) begin
            n_state = ST_IDLE;
            if (r_last) begin
                n_count    = '0;
                n_flags    = '0;
                n_idx      = '0;
                n_phase    = PH_FLAG;
                n_dist_low = '0;
                n_stopped  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_FLAG;
            r_count    <= '0;
            r_flags    <= '0;
            r_idx      <= '0;
            r_dist_low <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_flags    <= n_flags;
            r_idx      <= n_idx;
            r_dist_low <= n_dist_low;
            r_stopped  <= n_stopped;
        end
    end

    // captured item and copy state, no reset needed
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_dist <= n_dist;
        r_len  <= n_len;
        r_zero <= n_zero;
    end

    // output register: holds one result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob <= w_ld_byte;
            r_rl <= w_ld_last;
            r_pt <= w_cnt1_ext[TOTAL_W-1:0];
            r_lr <= w_next_limit;
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.out_byte       = r_ob;
    assign o_out.run_last       = r_rl;
    assign o_out.produced_total = r_pt;
    assign o_out.limit_reached  = r_lr;

`ifndef NO_ASSERTIONS
    // a new result never overwrites one still waiting for its transfer
    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ov || o_out.ready))
        else $error("result loaded over a pending output");

    // copy write-back only follows its own history read
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> ($past(r_state) == ST_RD || $past(r_state) == ST_WR))
        else $error("copy emit without history read");

    // a stopped stream produces nothing
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !w_load)
        else $error("byte produced after stream stopped");
`endif

endmodule
